### src/beam_shadow_mask_defines.svh
// Assertion macros shared by the beam shadow mask checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BEAM_SHADOW_MASK_DEFINES_SVH
`define BEAM_SHADOW_MASK_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define BSM_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("beam shadow mask: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define BSM_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("beam shadow mask: same-cycle check failed");

`endif

### src/bsm_pkg.sv
// Shared types and constants of the beam shadow mask.
// Depends on nothing; used by the controller, the datapath and the top level.
`default_nettype none

package bsm_pkg;

  // Field and arithmetic widths.
  localparam int ELEV_W      = 19;
  localparam int REF_W       = 21;
  localparam int STEP_W      = 17;
  localparam int TAN_W       = 41;
  localparam int RANGE_W     = 29;
  localparam int MAG_W       = 21;
  localparam int FRAC_W      = 16;
  localparam int DIVIDEND_W  = MAG_W + FRAC_W;
  localparam int CNT_W       = 6;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 41;

  // Divisor used for the first point of a profile (one metre in decimetres).
  localparam logic [RANGE_W-1:0] FIRST_DIVISOR = RANGE_W'(10);
  localparam logic [RANGE_W-1:0] RANGE_MAX     = '1;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_REF_ALT    = 2'd0,
    CFG_RANGE_STEP = 2'd1,
    CFG_TAN_UPPER  = 2'd2,
    CFG_TAN_LOWER  = 2'd3
  } cfg_idx_t;

  // One input item.
  typedef struct packed {
    logic signed [ELEV_W-1:0] elevation;
    logic                     sample_valid;
    logic                     profile_end;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic masked;
    logic end_of_profile;
  } out_item_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_RESOLVE
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### src/beam_shadow_mask.sv
// Top level of the beam shadow mask: joins the controller and the datapath.
// Depends on bsm_pkg, bsm_ctrl and bsm_dp.
//
// The block takes a terrain elevation profile one point per item and returns
// one item per point that says whether the point is masked (invalid, in terrain
// shadow or outside the beam). For each item the block accepts it, runs the 37
// steps of the radix-2 restoring divider that forms the look tangent (one
// quotient bit per cycle) and then tests the tangent and loads the output
// register. The result waits in that register while the next item is already
// accepted; only a result still unread when the following one resolves holds
// the block. Configuration must be written through cfg_we, cfg_addr and
// cfg_wdata only while no item is in flight; the block does not enforce this.
`default_nettype none

module beam_shadow_mask (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [bsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire bsm_pkg::in_item_t              in_item,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output bsm_pkg::out_item_t                  out_item
);

  bsm_pkg::cmd_t cmd;
  bsm_pkg::sts_t sts;

  // Sequencing of accept, divide and resolve.
  bsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Arithmetic, profile state and output register.
  bsm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### src/bsm_ctrl.sv
// Controller state machine of the beam shadow mask.
// Depends on bsm_pkg; drives the datapath through bsm_pkg::cmd_t.
`default_nettype none

module bsm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output bsm_pkg::cmd_t      cmd,
  input  wire bsm_pkg::sts_t sts
);

  bsm_pkg::state_t state_r;
  bsm_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bsm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      bsm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = bsm_pkg::ST_DIVIDE;
        end
      end
      bsm_pkg::ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          state_nxt = bsm_pkg::ST_RESOLVE;
        end
      end
      bsm_pkg::ST_RESOLVE: begin
        // Wait until the output register can take the item.
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = bsm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bsm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/bsm_dp.sv
// Datapath of the beam shadow mask: configuration registers, radix-2 divider,
// profile state and output register. Depends on bsm_pkg.
`default_nettype none

module bsm_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [bsm_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [bsm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire bsm_pkg::in_item_t                  in_item,
  input  wire bsm_pkg::cmd_t                      cmd,
  output bsm_pkg::sts_t                           sts,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output bsm_pkg::out_item_t                      out_item
);

  localparam int RW = bsm_pkg::RANGE_W;
  localparam int DW = bsm_pkg::DIVIDEND_W;
  localparam int TW = bsm_pkg::TAN_W;

  // Configuration registers.
  logic signed [bsm_pkg::REF_W-1:0]  ref_alt_r;
  logic [bsm_pkg::STEP_W-1:0]        range_step_r;
  logic signed [TW-1:0]              tan_upper_r;
  logic signed [TW-1:0]              tan_lower_r;

  // Divider and item registers.
  logic [DW-1:0]                     quot_r;
  logic [RW-1:0]                     rem_r;
  logic [RW-1:0]                     divisor_r;
  logic [bsm_pkg::CNT_W-1:0]         cnt_r;
  logic                              neg_r;
  logic                              valid_r;
  logic                              last_r;

  // Profile state.
  logic [RW-1:0]                     point_range_r;
  logic signed [TW-1:0]              run_lower_r;
  logic                              at_start_r;

  // Output register.
  logic                              out_valid_r;
  bsm_pkg::out_item_t                out_item_r;

  logic signed [bsm_pkg::REF_W:0]    diff;
  logic [bsm_pkg::REF_W:0]           diff_abs;
  logic [RW:0]                       rem_sh;
  logic [RW+1:0]                     rem_try;
  logic                              borrow;
  logic [TW-1:0]                     tan_abs;
  logic signed [TW-1:0]              tangent;
  logic signed [TW-1:0]              lower;
  logic                              pass;
  logic [RW:0]                       range_sum;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_alt_r    <= '0;
      range_step_r <= bsm_pkg::STEP_W'(1000);
      tan_upper_r  <= TW'(65536);
      tan_lower_r  <= -TW'(65536);
    end else if (cfg_we) begin
      case (cfg_addr)
        bsm_pkg::CFG_REF_ALT:    ref_alt_r    <= cfg_wdata[bsm_pkg::REF_W-1:0];
        bsm_pkg::CFG_RANGE_STEP: range_step_r <= cfg_wdata[bsm_pkg::STEP_W-1:0];
        bsm_pkg::CFG_TAN_UPPER:  tan_upper_r  <= cfg_wdata[TW-1:0];
        bsm_pkg::CFG_TAN_LOWER:  tan_lower_r  <= cfg_wdata[TW-1:0];
        default: ;
      endcase
    end
  end

  // Height difference to the reference altitude and its magnitude.
  always_comb begin
    diff     = (bsm_pkg::REF_W + 1)'(in_item.elevation) - (bsm_pkg::REF_W + 1)'(ref_alt_r);
    diff_abs = diff[bsm_pkg::REF_W] ? (bsm_pkg::REF_W + 1)'(-diff)
                                    : (bsm_pkg::REF_W + 1)'(diff);
  end

  // One restoring division step: shift in the next dividend bit and try to subtract.
  always_comb begin
    rem_sh  = {rem_r, quot_r[DW-1]};
    rem_try = {1'b0, rem_sh} - {2'b00, divisor_r};
    borrow  = rem_try[RW+1];
  end

  // Divider registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r    <= {diff_abs[bsm_pkg::MAG_W-1:0], {bsm_pkg::FRAC_W{1'b0}}};
      rem_r     <= '0;
      divisor_r <= (point_range_r != '0) ? point_range_r : bsm_pkg::FIRST_DIVISOR;
      neg_r     <= diff[bsm_pkg::REF_W];
      valid_r   <= in_item.sample_valid;
      last_r    <= in_item.profile_end;
    end else if (cmd.step) begin
      quot_r <= {quot_r[DW-2:0], ~borrow};
      if (!borrow) begin
        rem_r <= rem_try[RW-1:0];
      end else begin
        rem_r <= rem_sh[RW-1:0];
      end
    end
  end

  // Iteration counter; the division ends after one step per dividend bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= bsm_pkg::CNT_W'(DW - 1);
    end else if (cmd.step) begin
      cnt_r <= cnt_r - bsm_pkg::CNT_W'(1);
    end
  end

  // Signed tangent and the beam window test.
  always_comb begin
    tan_abs   = TW'(quot_r);
    tangent   = neg_r ? -$signed(tan_abs) : $signed(tan_abs);
    lower     = at_start_r ? tan_lower_r : run_lower_r;
    pass      = valid_r && (tangent >= lower) && (tangent <= tan_upper_r);
    range_sum = {1'b0, point_range_r} + (RW + 1)'(range_step_r);
  end

  // Profile state update when the item resolves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_range_r <= '0;
      at_start_r    <= 1'b1;
    end else if (cmd.finish) begin
      if (last_r) begin
        point_range_r <= '0;
      end else if (range_sum[RW]) begin
        point_range_r <= bsm_pkg::RANGE_MAX;
      end else begin
        point_range_r <= range_sum[RW-1:0];
      end
      at_start_r <= last_r;
    end
  end

  // Running lower tangent; a start of profile takes the configured edge.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      run_lower_r <= pass ? tangent : lower;
    end
  end

  // Output register: filled on resolve, emptied when the item is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item_r.masked         <= ~pass;
      out_item_r.end_of_profile <= last_r;
    end
  end

  // The count is only looked at while dividing, where it marks the last step.
  assign sts.div_done = (cnt_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

endmodule

`default_nettype wire

### src/bsm_checker.sv
// Port-level checks of the beam shadow mask, bound to the top level.
// Depends on bsm_pkg and the macros in beam_shadow_mask_defines.svh.
`default_nettype none
`include "beam_shadow_mask_defines.svh"

module bsm_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire bsm_pkg::out_item_t out_item
);

  // A stalled result stays offered.
  `BSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // A stalled result keeps its value.
  `BSM_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_item))

  // Only one item is worked on at a time: after an accept the input stalls.
  `BSM_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && !in_stall, in_stall)

  // A new result appears only while an item is being worked on.
  `BSM_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind beam_shadow_mask bsm_checker u_bsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire
